// File: hw/rtl/ecs_pkg.sv
// package for the exorlink cube split block
// field widths and the group code set; no dependencies

package ecs_pkg;

   localparam int CubeW = 32;
   localparam int DistW = 3;
   localparam int CodesW = 32;
   localparam int CodeW = 2;
   localparam int IdxW = 4;

   typedef enum logic [CodeW-1:0] {
      CODE_FIRST  = 2'd0,
      CODE_SECOND = 2'd1,
      CODE_OTHER  = 2'd2,
      CODE_KEEP   = 2'd3
   } code_type;

endpackage

// File: hw/rtl/esop_exorlink_cube_split.sv
// exorlink cube split: orders two cubes and emits one new cube per distance step
// depends on ecs_pkg for field widths and group codes
//
// usage
// - req channel: one item is two cubes (mask and polarity words), a distance
//   and sixteen packed 2-bit group codes; accepted when req_valid is high and
//   req_stall is low
// - rsp channel: one item per produced cube; rsp_last_cube marks the final
//   cube of an input's run; taken when rsp_valid is high and rsp_stall is low
// - an input with distance d gives min(d, MAX_DISTANCE) result items, one per
//   cycle while the receiver does not stall; distance zero gives none
// - the first result of an input passes the input register, then the result
//   register
// - the single result register takes one cube a cycle from the held input
//   while the receiver does not stall
// - the next input is taken in the same cycle the last step of the held one
//   moves into the result register
// - while the receiver stalls, the result register holds and the held input
//   waits; req_stall rises once the held input still has steps to give
// - reset (synchronous, active high) drops the held input and any result

module esop_exorlink_cube_split #(
   parameter int MAX_DISTANCE = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ecs_pkg::CubeW-1:0]  req_first_mask,
   input  logic [ecs_pkg::CubeW-1:0]  req_first_polarity,
   input  logic [ecs_pkg::CubeW-1:0]  req_second_mask,
   input  logic [ecs_pkg::CubeW-1:0]  req_second_polarity,
   input  logic [ecs_pkg::DistW-1:0]  req_link_distance,
   input  logic [ecs_pkg::CodesW-1:0] req_group_codes,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ecs_pkg::CubeW-1:0]  rsp_result_mask,
   output logic [ecs_pkg::CubeW-1:0]  rsp_result_polarity,
   output logic                       rsp_last_cube
);

   localparam int StepW = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;
   localparam logic [ecs_pkg::DistW-1:0] MaxDist = ecs_pkg::DistW'(MAX_DISTANCE);

   // held input
   logic                       h_valid_ff, h_valid_in;
   logic [StepW-1:0]           step_ff, step_in;
   logic [ecs_pkg::DistW-1:0]  dist_ff, dist_in;
   logic [ecs_pkg::CubeW-1:0]  am_ff, am_in, ap_ff, ap_in, bm_ff, bm_in, bp_ff, bp_in;
   logic [ecs_pkg::CubeW-1:0]  om_ff, om_in, op_ff, op_in;
   logic [ecs_pkg::CodesW-1:0] codes_ff, codes_in;
   logic [ecs_pkg::CubeW-1:0]  bit_ff [MAX_DISTANCE];
   logic [ecs_pkg::CubeW-1:0]  bit_in [MAX_DISTANCE];

   // result register
   logic                       o_valid_ff, o_valid_in;
   logic [ecs_pkg::CubeW-1:0]  rm_ff, rm_in, rp_ff, rp_in;
   logic                       last_ff, last_in;

   logic req_accept, o_load, h_last, swap;
   logic [ecs_pkg::CubeW-1:0] diff, rest;
   logic [ecs_pkg::DistW-1:0] dist_sat;

   assign o_load     = h_valid_ff && (!o_valid_ff || !rsp_stall);
   assign h_last     = ({{(ecs_pkg::DistW-StepW){1'b0}}, step_ff} + ecs_pkg::DistW'(1))
                       == dist_ff;
   assign req_stall  = h_valid_ff && !(o_load && h_last);
   assign req_accept = req_valid && !req_stall;

   // input side: order the cubes, find the lowest differing positions
   always_comb begin
      swap     = {req_first_polarity, req_first_mask} > {req_second_polarity, req_second_mask};
      dist_sat = (req_link_distance > MaxDist) ? MaxDist : req_link_distance;
      diff     = (req_first_polarity ^ req_second_polarity)
               | (req_first_mask ^ req_second_mask);
      rest     = diff;
      for (int j = 0; j < MAX_DISTANCE; j++) begin
         bit_in[j] = rest & (~rest + ecs_pkg::CubeW'(1));
         rest      = rest & (rest - ecs_pkg::CubeW'(1));
      end
      am_in    = swap ? req_second_mask : req_first_mask;
      ap_in    = swap ? req_second_polarity : req_first_polarity;
      bm_in    = swap ? req_first_mask : req_second_mask;
      bp_in    = swap ? req_first_polarity : req_second_polarity;
      om_in    = req_first_mask ^ req_second_mask;
      op_in    = ~req_first_polarity & ~req_second_polarity;
      codes_in = req_group_codes;
      dist_in  = dist_sat;
   end

   always_comb begin
      h_valid_in = h_valid_ff;
      step_in    = step_ff;
      if (o_load) begin
         step_in = step_ff + StepW'(1);
         if (h_last) begin
            h_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         h_valid_in = (dist_sat != '0);
         step_in    = '0;
      end
   end

   // step logic: apply this step's group codes at the held positions
   always_comb begin
      logic [ecs_pkg::IdxW-1:0] base;
      logic [ecs_pkg::IdxW-1:0] idx;
      ecs_pkg::code_type        code;
      base = ecs_pkg::IdxW'(step_ff) * ecs_pkg::IdxW'(dist_ff);
      rm_in = am_ff;
      rp_in = ap_ff;
      for (int j = 0; j < MAX_DISTANCE; j++) begin
         idx  = base + ecs_pkg::IdxW'(j);
         code = ecs_pkg::code_type'(codes_ff[ecs_pkg::CodeW*idx +: ecs_pkg::CodeW]);
         if (ecs_pkg::DistW'(j) < dist_ff) begin
            unique case (code)
               ecs_pkg::CODE_SECOND: begin
                  rm_in = (rm_in & ~bit_ff[j]) | (bm_ff & bit_ff[j]);
                  rp_in = (rp_in & ~bit_ff[j]) | (bp_ff & bit_ff[j]);
               end
               ecs_pkg::CODE_OTHER: begin
                  rm_in = (rm_in & ~bit_ff[j]) | (om_ff & bit_ff[j]);
                  rp_in = (rp_in & ~bit_ff[j]) | (op_ff & bit_ff[j]);
               end
               ecs_pkg::CODE_FIRST, ecs_pkg::CODE_KEEP: begin
               end
            endcase
         end
      end
      last_in    = h_last;
      o_valid_in = o_load ? 1'b1 : (o_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         step_ff    <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= h_valid_in;
         step_ff    <= step_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dist_ff  <= dist_in;
         am_ff    <= am_in;
         ap_ff    <= ap_in;
         bm_ff    <= bm_in;
         bp_ff    <= bp_in;
         om_ff    <= om_in;
         op_ff    <= op_in;
         codes_ff <= codes_in;
         bit_ff   <= bit_in;
      end
      if (o_load) begin
         rm_ff   <= rm_in;
         rp_ff   <= rp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_result_mask     = rm_ff;
   assign rsp_result_polarity = rp_ff;
   assign rsp_last_cube       = last_ff;

`ifndef SYNTHESIS
   a_held_dist: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> (dist_ff != '0) && (dist_ff <= MaxDist))
      else $error("held item has a bad distance");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> ({{(ecs_pkg::DistW-StepW){1'b0}}, step_ff} < dist_ff))
      else $error("step counter past distance");

   a_run_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_cube |-> h_valid_ff)
      else $error("run ended without a last cube");
`endif

endmodule

// File: sim/tb_top.sv
// testbench for esop_exorlink_cube_split: directed and random cube pairs with
// a scoreboard that predicts the split cubes and checks each result item
// depends on ecs_pkg and the esop_exorlink_cube_split rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int MaxDist = 4;

   typedef struct packed {
      logic [ecs_pkg::CubeW-1:0] mask;
      logic [ecs_pkg::CubeW-1:0] polarity;
      logic                      last;
   } cube_type;

   class cube_scoreboard;
      cube_type expected_cubes[$];
      int       fails = 0;

      function void add_split_cubes(logic [ecs_pkg::CubeW-1:0] am,
                                    logic [ecs_pkg::CubeW-1:0] ap,
                                    logic [ecs_pkg::CubeW-1:0] bm,
                                    logic [ecs_pkg::CubeW-1:0] bp,
                                    logic [ecs_pkg::DistW-1:0] link_dist,
                                    logic [ecs_pkg::CodesW-1:0] codes);
         int                        d;
         int                        idx;
         logic [ecs_pkg::CubeW-1:0] tmp;
         logic [ecs_pkg::CubeW-1:0] diff;
         logic [ecs_pkg::CubeW-1:0] om;
         logic [ecs_pkg::CubeW-1:0] op;
         logic [ecs_pkg::CubeW-1:0] rest;
         logic [ecs_pkg::CubeW-1:0] lowbit;
         cube_type                  cube;
         ecs_pkg::code_type         code;
         d = (int'(link_dist) > MaxDist) ? MaxDist : int'(link_dist);
         if ({ap, am} > {bp, bm}) begin
            tmp = am; am = bm; bm = tmp;
            tmp = ap; ap = bp; bp = tmp;
         end
         diff = (ap ^ bp) | (am ^ bm);
         om = am ^ bm;
         op = ~ap & ~bp;
         for (int s = 0; s < d; s++) begin
            cube.mask = am;
            cube.polarity = ap;
            rest = diff;
            for (int j = 0; j < d; j++) begin
               idx = (s * d + j) & 15;
               code = ecs_pkg::code_type'(codes[2*idx +: ecs_pkg::CodeW]);
               lowbit = rest & (~rest + 32'd1);
               rest = rest & (rest - 32'd1);
               case (code)
                  ecs_pkg::CODE_SECOND: begin
                     cube.mask = (cube.mask & ~lowbit) | (bm & lowbit);
                     cube.polarity = (cube.polarity & ~lowbit) | (bp & lowbit);
                  end
                  ecs_pkg::CODE_OTHER: begin
                     cube.mask = (cube.mask & ~lowbit) | (om & lowbit);
                     cube.polarity = (cube.polarity & ~lowbit) | (op & lowbit);
                  end
                  default: ;
               endcase
            end
            cube.last = (s + 1 == d);
            expected_cubes.insert(expected_cubes.size(), cube);
         end
      endfunction

      function void check_cube(logic [ecs_pkg::CubeW-1:0] mask,
                               logic [ecs_pkg::CubeW-1:0] polarity, logic last);
         cube_type exp_cube;
         if (expected_cubes.size() == 0) begin
            $error("result item with none expected: mask %h polarity %h last %b",
                   mask, polarity, last);
            fails++;
            return;
         end
         exp_cube = expected_cubes.pop_front();
         if (mask !== exp_cube.mask) begin
            $error("result_mask: expected %h, actual %h", exp_cube.mask, mask);
            fails++;
         end
         if (polarity !== exp_cube.polarity) begin
            $error("result_polarity: expected %h, actual %h", exp_cube.polarity, polarity);
            fails++;
         end
         if (last !== exp_cube.last) begin
            $error("last_cube: expected %b, actual %b", exp_cube.last, last);
            fails++;
         end
      endfunction

      function int pending();
         return expected_cubes.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [ecs_pkg::CubeW-1:0]  req_first_mask;
   logic [ecs_pkg::CubeW-1:0]  req_first_polarity;
   logic [ecs_pkg::CubeW-1:0]  req_second_mask;
   logic [ecs_pkg::CubeW-1:0]  req_second_polarity;
   logic [ecs_pkg::DistW-1:0]  req_link_distance;
   logic [ecs_pkg::CodesW-1:0] req_group_codes;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ecs_pkg::CubeW-1:0]  rsp_result_mask;
   logic [ecs_pkg::CubeW-1:0]  rsp_result_polarity;
   logic                       rsp_last_cube;

   cube_scoreboard sb = new();
   int idle_pct = 10;
   int hold_left = 0;

   esop_exorlink_cube_split #(
      .MAX_DISTANCE(MaxDist)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_mask(req_first_mask),
      .req_first_polarity(req_first_polarity),
      .req_second_mask(req_second_mask),
      .req_second_polarity(req_second_polarity),
      .req_link_distance(req_link_distance),
      .req_group_codes(req_group_codes),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_mask(rsp_result_mask),
      .rsp_result_polarity(rsp_result_polarity),
      .rsp_last_cube(rsp_last_cube)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("esop_exorlink_cube_split: mismatch");
      $finish;
   end

   // result side: check taken items, then pick next stall
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            sb.check_cube(rsp_result_mask, rsp_result_polarity, rsp_last_cube);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   task automatic offer_pair(logic [ecs_pkg::CubeW-1:0] am, logic [ecs_pkg::CubeW-1:0] ap,
                             logic [ecs_pkg::CubeW-1:0] bm, logic [ecs_pkg::CubeW-1:0] bp,
                             logic [ecs_pkg::DistW-1:0] link_dist,
                             logic [ecs_pkg::CodesW-1:0] codes);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_mask <= am;
      req_first_polarity <= ap;
      req_second_mask <= bm;
      req_second_polarity <= bp;
      req_link_distance <= link_dist;
      req_group_codes <= codes;
      do
         @(posedge clock);
      while (req_stall);
      sb.add_split_cubes(am, ap, bm, bp, link_dist, codes);
   endtask

   task automatic offer_random_pair();
      logic [ecs_pkg::CubeW-1:0]  am;
      logic [ecs_pkg::CubeW-1:0]  ap;
      logic [ecs_pkg::CubeW-1:0]  bm;
      logic [ecs_pkg::CubeW-1:0]  bp;
      logic [ecs_pkg::DistW-1:0]  link_dist;
      logic [ecs_pkg::CodesW-1:0] codes;
      int                         flips;
      int                         lo;
      am = $urandom;
      ap = $urandom;
      bm = $urandom;
      bp = $urandom;
      if ($urandom_range(99) < 70) begin
         // second cube a few literals away from the first
         bm = am;
         bp = ap;
         flips = $urandom_range(0, 6);
         lo = ($urandom_range(3) == 0) ? 20 : 0;
         for (int k = 0; k < flips; k++) begin
            if ($urandom_range(1))
               bm[$urandom_range(lo, 31)] ^= 1'b1;
            else
               bp[$urandom_range(lo, 31)] ^= 1'b1;
         end
         if ($urandom_range(1)) begin
            {am, bm} = {bm, am};
            {ap, bp} = {bp, ap};
         end
      end
      if ($urandom_range(99) < 80)
         link_dist = ecs_pkg::DistW'($urandom_range(1, 4));
      else
         link_dist = ecs_pkg::DistW'($urandom_range(0, 7));
      codes = $urandom;
      offer_pair(am, ap, bm, bp, link_dist, codes);
   endtask

   initial begin
      int drain;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_first_mask <= '0;
      req_first_polarity <= '0;
      req_second_mask <= '0;
      req_second_polarity <= '0;
      req_link_distance <= '0;
      req_group_codes <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      offer_pair('0, '0, '0, '0, 3'd0, '0);
      offer_pair('1, '1, '0, '0, 3'd0, '1);
      offer_pair('0, '0, '0, '0, 3'd4, 32'h5555_5555);
      offer_pair('0, '0, '1, '1, 3'd4, 32'h0000_0000);
      offer_pair('0, '0, '1, '1, 3'd4, 32'h5555_5555);
      offer_pair('0, '0, '1, '1, 3'd4, 32'hAAAA_AAAA);
      offer_pair('0, '0, '1, '1, 3'd4, 32'hFFFF_FFFF);
      offer_pair('1, '1, '0, '0, 3'd4, 32'h1B1B_1B1B);
      offer_pair('1, '0, '0, '1, 3'd3, 32'hE4E4_E4E4);
      offer_pair(32'h0000_00F0, 32'h0000_0F00, 32'h0000_0FF0, 32'h0000_00F0, 3'd1,
                 32'h0000_0002);
      offer_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5679, 32'h9ABC_DEF3, 3'd2,
                 32'h0000_0096);
      offer_pair(32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 3'd3,
                 32'hAAAA_AAAA);
      offer_pair(32'h0000_0001, 32'h0, 32'h0, 32'h0, 3'd4, 32'hAAAA_AAAA);
      offer_pair(32'h8000_0000, 32'h5, 32'h0000_0001, 32'h5, 3'd2, 32'h0000_0009);
      offer_pair(32'h0, 32'h8000_0000, 32'h0, 32'h0, 3'd4, 32'h5555_5555);
      offer_pair($urandom, $urandom, $urandom, $urandom, 3'd5, $urandom);
      offer_pair($urandom, $urandom, $urandom, $urandom, 3'd6, $urandom);
      offer_pair($urandom, $urandom, $urandom, $urandom, 3'd7, $urandom);
      offer_pair(32'hFFFF_0000, 32'h00FF_FF00, 32'h0000_FFFF, 32'hFF00_00FF, 3'd4,
                 32'hE4E4_E4E4);
      offer_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4,
                 32'h6C6C_6C6C);

      // random
      for (int n = 0; n < 400; n++) begin
         if (n == 100)
            hold_left = 80;
         if (n == 200) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if (n == 250)
            idle_pct = 0;
         if (n == 330)
            idle_pct = 10;
         offer_random_pair();
      end
      req_valid <= 1'b0;

      drain = 0;
      while (sb.pending() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d result items never arrived", sb.pending());
         sb.fails++;
      end
      if (sb.fails == 0)
         $display("esop_exorlink_cube_split: match");
      else
         $display("esop_exorlink_cube_split: mismatch");
      $finish;
   end

endmodule
